// ----- rtl/bspline_curve_evaluator_macros.svh -----
// Assertion macros for the B-spline evaluator; empty when SYNTH is defined.
`ifndef BSPLINE_CURVE_EVALUATOR_MACROS_SVH
`define BSPLINE_CURVE_EVALUATOR_MACROS_SVH
`ifndef SYNTH
`define BSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSP_ASSERT_IMP(lbl, ante, cons, msg)
`define BSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/bsp_pkg.sv -----
package bsp_pkg;

  localparam int BASIS_W = 31;
  localparam logic [BASIS_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam int COORD_W = 12;
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam int CURVE_W = 20;
  localparam int PC_W = 7;
  localparam int CO_W = 4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_ORDER   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_MUL, S_DLD, S_DIV, S_UPD, S_DEND, S_RD, S_PMUL, S_ADD, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_INIT, OP_MUL, OP_DLD, OP_DSTEP, OP_UPD,
    OP_DEND, OP_RD, OP_PMUL, OP_ADD, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic order_bad;
    logic pts_missing;
  } dp_stat_t;

endpackage

// ----- rtl/bsp_ram.sv -----
module bsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bsp_ctrl.sv -----
`include "bspline_curve_evaluator_macros.svh"
module bsp_ctrl import bsp_pkg::*; #(
  parameter int MAX_ORDER = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         in_kind,
  input  logic [CO_W-1:0]              curve_order,
  input  dp_stat_t                     stat,
  output logic                         busy,
  output dp_cmd_t                      cmd,
  output logic [$clog2(MAX_ORDER)-1:0] r_idx,
  output logic [$clog2(MAX_ORDER)-1:0] d_idx
);

  localparam int RW = $clog2(MAX_ORDER);
  localparam int KOW = $clog2(MAX_ORDER + 1);
  localparam int CW = $clog2(BASIS_W);

  state_t state_r, state_nxt;
  logic [RW-1:0] r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [KOW-1:0] k_eff;
  logic [RW-1:0] deg;

  always_comb begin
    if (curve_order < 4'd2) begin
      k_eff = KOW'(2);
    end else if (KOW'(curve_order) > KOW'(MAX_ORDER)) begin
      k_eff = KOW'(MAX_ORDER);
    end else begin
      k_eff = KOW'(curve_order);
    end
  end
  assign deg = RW'(k_eff - KOW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r <= '0;
      d_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      r_r <= r_nxt;
      d_r <= d_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_kind) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op = OP_START;
            if (!(stat.order_bad || stat.pts_missing)) begin
              state_nxt = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        cmd.op = OP_INIT;
        d_nxt = RW'(1);
        r_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        state_nxt = S_DLD;
      end
      S_DLD: begin
        cmd.op = OP_DLD;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DSTEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(BASIS_W - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op = OP_UPD;
        if (r_r == d_r - RW'(1)) begin
          state_nxt = S_DEND;
        end else begin
          r_nxt = r_r + RW'(1);
          state_nxt = S_MUL;
        end
      end
      S_DEND: begin
        cmd.op = OP_DEND;
        r_nxt = '0;
        if (d_r == deg) begin
          state_nxt = S_RD;
        end else begin
          d_nxt = d_r + RW'(1);
          state_nxt = S_MUL;
        end
      end
      S_RD: begin
        cmd.op = OP_RD;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        cmd.op = OP_PMUL;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (r_r == deg) begin
          state_nxt = S_OUT;
        end else begin
          r_nxt = r_r + RW'(1);
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign r_idx = r_r;
  assign d_idx = d_r;

  `BSP_ASSERT_IMP(a_blend_row, state_r == S_MUL, r_r < d_r, "blend index past row")
  `BSP_ASSERT_IMP(a_row_deg, state_r == S_MUL, d_r <= deg && d_r != '0, "row past degree")
  `BSP_ASSERT_NXT(a_div_len, state_r == S_DLD, state_r == S_DIV && cnt_r == '0,
                  "divide did not start clean")

endmodule

// ----- rtl/bsp_dp.sv -----
`include "bspline_curve_evaluator_macros.svh"
module bsp_dp import bsp_pkg::*; #(
  parameter int MAX_CTRL_POINTS = 64,
  parameter int MAX_ORDER = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  input  logic [$clog2(MAX_ORDER)-1:0] r_idx,
  input  logic [$clog2(MAX_ORDER)-1:0] d_idx,
  input  logic [PC_W-1:0]              point_count,
  input  logic [CO_W-1:0]              curve_order,
  input  logic [COORD_W-1:0]           in_point_x,
  input  logic [COORD_W-1:0]           in_point_y,
  input  logic [T_W-1:0]               in_param_t,
  output dp_stat_t                     stat,
  output logic                         out_valid,
  output logic [CURVE_W-1:0]           out_curve_x,
  output logic [CURVE_W-1:0]           out_curve_y,
  output logic [1:0]                   out_status
);

  localparam int RW = $clog2(MAX_ORDER);
  localparam int KOW = $clog2(MAX_ORDER + 1);
  localparam int NW = $clog2(MAX_CTRL_POINTS + 1);
  localparam int AW = $clog2(MAX_CTRL_POINTS);
  localparam int TW = T_W + NW;
  localparam int PW = $clog2(MAX_CTRL_POINTS + MAX_ORDER + 1);
  localparam int PRW = BASIS_W + TW;
  localparam int MW = BASIS_W + COORD_W;
  localparam int SW = MW + 1;
  localparam int CMPW = (NW > PC_W) ? NW : PC_W;

  logic [NW-1:0] n_eff, spans, loaded_r, span_r;
  logic [KOW-1:0] k_eff;
  logic [RW-1:0] deg;
  logic [T_W-1:0] t_sat;
  logic [TW-1:0] tt_w, tt_r;
  logic [NW:0] span_raw;
  logic [PW-1:0] mu, p_hi, p_lo;
  logic [TW-1:0] knot_hi, knot_lo, right_w, den_w, den_r, rem_r;
  logic [PRW-1:0] prod_r;
  logic [BASIS_W-1:0] q_r, carry_r, a_w, bsel;
  logic [BASIS_W-1:0] basis_r [MAX_ORDER];
  logic [TW:0] shifted, diff;
  logic [MW-1:0] px_r, py_r;
  logic [SW-1:0] sx_r, sy_r, sx_rnd, sy_rnd;
  logic [2*COORD_W-1:0] rdata;
  logic ram_we;
  logic out_valid_r;
  logic [CURVE_W-1:0] out_x_r, out_y_r;
  logic [1:0] out_status_r;

  function automatic logic [TW-1:0] knot(input logic [PW-1:0] p, input logic [NW-1:0] n,
                                         input logic [KOW-1:0] k, input logic [NW-1:0] s);
    logic [PW-1:0] q;
    q = p - PW'(k) + PW'(1);
    if (p < PW'(k)) begin
      return '0;
    end else if (p >= PW'(n)) begin
      return TW'(s) << 16;
    end else begin
      return TW'(q) << 16;
    end
  endfunction

  always_comb begin
    if (point_count == '0) begin
      n_eff = NW'(1);
    end else if (CMPW'(point_count) > CMPW'(MAX_CTRL_POINTS)) begin
      n_eff = NW'(MAX_CTRL_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
    if (curve_order < 4'd2) begin
      k_eff = KOW'(2);
    end else if (KOW'(curve_order) > KOW'(MAX_ORDER)) begin
      k_eff = KOW'(MAX_ORDER);
    end else begin
      k_eff = KOW'(curve_order);
    end
  end

  assign deg = RW'(k_eff - KOW'(1));
  assign spans = n_eff - NW'(k_eff) + NW'(1);
  assign stat.order_bad = (NW'(k_eff) > n_eff);
  assign stat.pts_missing = (loaded_r < n_eff);

  assign t_sat = (in_param_t > T_ONE) ? T_ONE : in_param_t;
  assign tt_w = TW'(t_sat) * TW'(spans);
  assign span_raw = tt_w[TW-1:16];

  assign mu = PW'(span_r) + PW'(deg);
  assign p_hi = mu + PW'(r_idx) + PW'(1);
  assign p_lo = mu + PW'(1) - PW'(d_idx) + PW'(r_idx);
  assign knot_hi = knot(p_hi, n_eff, k_eff, spans);
  assign knot_lo = knot(p_lo, n_eff, k_eff, spans);
  assign right_w = knot_hi - tt_r;
  assign den_w = knot_hi - knot_lo;

  assign bsel = basis_r[r_idx];
  assign shifted = {rem_r, q_r[BASIS_W-1]};
  assign diff = shifted - {1'b0, den_r};
  assign a_w = (den_r == '0) ? '0 : q_r;

  assign ram_we = (cmd.op == OP_LOAD) && (loaded_r < n_eff);

  bsp_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_CTRL_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(loaded_r[AW-1:0]),
    .wdata({in_point_x, in_point_y}),
    .raddr(AW'(span_r + NW'(r_idx))),
    .rdata(rdata)
  );

  assign sx_rnd = sx_r + SW'(22'h20_0000);
  assign sy_rnd = sy_r + SW'(22'h20_0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (ram_we) begin
        loaded_r <= loaded_r + NW'(1);
      end
      if (cmd.op == OP_START && (stat.order_bad || stat.pts_missing)) begin
        out_valid_r <= 1'b1;
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        tt_r <= tt_w;
        span_r <= (span_raw >= (NW+1)'(spans)) ? spans - NW'(1) : NW'(span_raw);
        out_x_r <= '0;
        out_y_r <= '0;
        out_status_r <= stat.order_bad ? STAT_ORDER : STAT_MISSING;
      end
      OP_INIT: begin
        basis_r[0] <= ONE_Q30;
        carry_r <= '0;
        sx_r <= '0;
        sy_r <= '0;
      end
      OP_MUL: begin
        prod_r <= PRW'(bsel) * PRW'(right_w);
        den_r <= den_w;
      end
      OP_DLD: begin
        rem_r <= prod_r[PRW-1:BASIS_W];
        q_r <= prod_r[BASIS_W-1:0];
      end
      OP_DSTEP: begin
        // restoring step: keep the trial difference when it did not borrow
        rem_r <= diff[TW] ? shifted[TW-1:0] : diff[TW-1:0];
        q_r <= {q_r[BASIS_W-2:0], ~diff[TW]};
      end
      OP_UPD: begin
        basis_r[r_idx] <= carry_r + a_w;
        carry_r <= bsel - a_w;
      end
      OP_DEND: begin
        basis_r[d_idx] <= carry_r;
        carry_r <= '0;
      end
      OP_PMUL: begin
        px_r <= MW'(bsel) * MW'(rdata[2*COORD_W-1:COORD_W]);
        py_r <= MW'(bsel) * MW'(rdata[COORD_W-1:0]);
      end
      OP_ADD: begin
        sx_r <= sx_r + SW'(px_r);
        sy_r <= sy_r + SW'(py_r);
      end
      OP_OUT: begin
        out_x_r <= sx_rnd[22 +: CURVE_W];
        out_y_r <= sy_rnd[22 +: CURVE_W];
        out_status_r <= STAT_OK;
      end
      OP_NONE, OP_LOAD, OP_RD: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_curve_x = out_x_r;
  assign out_curve_y = out_y_r;
  assign out_status = out_status_r;

  `BSP_ASSERT_IMP(a_blend_le, cmd.op == OP_UPD && den_r != '0, q_r <= bsel,
                  "blend share exceeds basis value")
  `BSP_ASSERT_IMP(a_err_zero, out_valid_r && out_status_r != STAT_OK,
                  out_x_r == '0 && out_y_r == '0, "error word carries a point")
  `BSP_ASSERT_NXT(a_load_cnt, ram_we, loaded_r == $past(loaded_r) + NW'(1),
                  "load count did not advance")

endmodule

// ----- rtl/bspline_curve_evaluator.sv -----
// Clamped uniform B-spline curve evaluator. A start with in_kind 0 appends a
// control point (points past point_count are dropped; only reset empties the
// store). A start with in_kind 1 evaluates the curve at in_param_t and gives
// one result word, shown for exactly one cycle with out_valid high; the
// receiver cannot stall, so it must take the word in that cycle. With a bad
// status (order above count, or points missing) the word comes in the cycle
// after start. Otherwise an evaluation of degree order-1 keeps busy high
// until its last step, and the word follows in the next cycle. Its run time
// is dominated by the basis blends of the Cox-de Boor triangle: each blend
// runs one multiply and a one-bit-per-cycle 31-step restoring divider, shared
// by all blends.
// Write point_count and curve_order only while busy is low and no word is due.
module bspline_curve_evaluator import bsp_pkg::*; #(
  parameter int MAX_CTRL_POINTS = 64,
  parameter int MAX_ORDER = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic [T_W-1:0]     in_param_t,
  output logic               out_valid,
  output logic [CURVE_W-1:0] out_curve_x,
  output logic [CURVE_W-1:0] out_curve_y,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RW = $clog2(MAX_ORDER);

  logic [PC_W-1:0] point_count_r;
  logic [CO_W-1:0] curve_order_r;
  logic cfg_wr;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [RW-1:0] r_idx, d_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PC_W'(4);
      curve_order_r <= CO_W'(3);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        curve_order_r <= pwdata[CO_W-1:0];
      end else begin
        point_count_r <= pwdata[PC_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32-CO_W){1'b0}}, curve_order_r}
                           : {{(32-PC_W){1'b0}}, point_count_r};

  bsp_ctrl #(
    .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_kind    (in_kind),
    .curve_order(curve_order_r),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd),
    .r_idx      (r_idx),
    .d_idx      (d_idx)
  );

  bsp_dp #(
    .MAX_CTRL_POINTS(MAX_CTRL_POINTS),
    .MAX_ORDER      (MAX_ORDER)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .r_idx      (r_idx),
    .d_idx      (d_idx),
    .point_count(point_count_r),
    .curve_order(curve_order_r),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_param_t (in_param_t),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_curve_x(out_curve_x),
    .out_curve_y(out_curve_y),
    .out_status (out_status)
  );

endmodule

// ----- tb/bspline_curve_evaluator_checker.sv -----
module bspline_curve_evaluator_checker import bsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_kind,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic [T_W-1:0]     in_param_t,
  input  logic               out_valid,
  input  logic [CURVE_W-1:0] out_curve_x,
  input  logic [CURVE_W-1:0] out_curve_y,
  input  logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_points
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int NORD = 8;
  localparam logic [2:0] ADDR_COUNT = 3'd0;
  localparam logic [2:0] ADDR_ORDER = 3'd4;

  typedef struct packed {
    logic [CURVE_W-1:0] cx;
    logic [CURVE_W-1:0] cy;
    logic [1:0]         st;
  } curve_word_t;

  logic [COORD_W-1:0] px_mem [NPTS];
  logic [COORD_W-1:0] py_mem [NPTS];
  int unsigned stored;
  logic [PC_W-1:0] cnt_reg;
  logic [CO_W-1:0] ord_reg;
  curve_word_t curve_q[$];

  function automatic longint unsigned knot(int unsigned p, int unsigned n, int unsigned k,
                                           int unsigned spans);
    if (p < k) return 0;
    if (p >= n) return longint'(spans) * 65536;
    return longint'(p - k + 1) * 65536;
  endfunction

  function automatic curve_word_t eval_curve(logic [T_W-1:0] tin);
    int unsigned n, k, spans, deg, mu, sp, idx;
    longint unsigned t, tt, sx, sy, carry, den, a, rest;
    longint unsigned bas [NORD];
    longint unsigned lft [NORD+1];
    longint unsigned rgt [NORD+1];
    curve_word_t w;
    n = (cnt_reg < 1) ? 1 : (cnt_reg > NPTS) ? NPTS : cnt_reg;
    k = (ord_reg < 2) ? 2 : (ord_reg > NORD) ? NORD : ord_reg;
    w = '0;
    if (k > n) begin
      w.st = STAT_ORDER;
      return w;
    end
    if (stored < n) begin
      w.st = STAT_MISSING;
      return w;
    end
    spans = n - k + 1;
    deg = k - 1;
    t = (tin > T_ONE) ? 65536 : tin;
    tt = t * spans;
    sp = int'(tt >> 16);
    if (sp >= spans) sp = spans - 1;
    mu = sp + deg;
    bas[0] = 64'd1 << 30;
    for (int d = 1; d <= deg; d++) begin
      carry = 0;
      lft[d] = tt - knot(mu + 1 - d, n, k, spans);
      rgt[d] = knot(mu + d, n, k, spans) - tt;
      for (int r = 0; r < d; r++) begin
        den = rgt[r+1] + lft[d-r];
        a = (den != 0) ? (bas[r] * rgt[r+1]) / den : 0;
        rest = bas[r] - a;
        bas[r] = carry + a;
        carry = rest;
      end
      bas[d] = carry;
    end
    sx = 0;
    sy = 0;
    for (int r = 0; r <= deg; r++) begin
      idx = (sp + r) % NPTS;
      sx += bas[r] * px_mem[idx];
      sy += bas[r] * py_mem[idx];
    end
    w.cx = CURVE_W'((sx + (64'd1 << 21)) >> 22);
    w.cy = CURVE_W'((sy + (64'd1 << 21)) >> 22);
    w.st = STAT_OK;
    return w;
  endfunction

  assign pending_points = curve_q.size();

  always @(posedge clk) begin
    curve_word_t want;
    int unsigned n;
    int errs;
    errs = 0;
    if (!rst_n) begin
      stored <= 0;
      cnt_reg <= PC_W'(4);
      ord_reg <= CO_W'(3);
      curve_q.delete();
      fail_count <= 0;
      for (int i = 0; i < NPTS; i++) begin
        px_mem[i] <= '0;
        py_mem[i] <= '0;
      end
    end else begin
      if (out_valid) begin
        if (curve_q.size() == 0) begin
          $error("unexpected result word");
          errs++;
        end else begin
          want = curve_q.pop_front();
          if (out_curve_x !== want.cx) begin
            $error("curve_x expected %0d actual %0d", want.cx, out_curve_x);
            errs++;
          end
          if (out_curve_y !== want.cy) begin
            $error("curve_y expected %0d actual %0d", want.cy, out_curve_y);
            errs++;
          end
          if (out_status !== want.st) begin
            $error("status expected %0d actual %0d", want.st, out_status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (start && !busy) begin
        if (in_kind) begin
          curve_q = {curve_q, eval_curve(in_param_t)};
        end else begin
          n = (cnt_reg < 1) ? 1 : (cnt_reg > NPTS) ? NPTS : cnt_reg;
          if (stored < n) begin
            px_mem[stored] <= in_point_x;
            py_mem[stored] <= in_point_y;
            stored <= stored + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_COUNT) cnt_reg <= pwdata[PC_W-1:0];
        else if (paddr == ADDR_ORDER) ord_reg <= pwdata[CO_W-1:0];
      end
    end
  end
endmodule

// ----- tb/bspline_curve_evaluator_tb.sv -----
module bspline_curve_evaluator_tb import bsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_COUNT = 3'd0;
  localparam logic [2:0] ADDR_ORDER = 3'd4;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_kind = 0;
  logic [COORD_W-1:0] in_point_x = '0;
  logic [COORD_W-1:0] in_point_y = '0;
  logic [T_W-1:0] in_param_t = '0;
  logic out_valid;
  logic [CURVE_W-1:0] out_curve_x, out_curve_y;
  logic [1:0] out_status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending_points;

  always #5 clk = ~clk;

  bspline_curve_evaluator dut (.*);
  bspline_curve_evaluator_checker chk (.*);

  // drop start only when a gap follows; the next item takes over otherwise
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // hold start past the accepting edge; a gap, a drain or a write drops it
  task automatic issue(logic kind, logic [11:0] x, logic [11:0] y, logic [16:0] t);
    in_kind <= kind;
    in_point_x <= x;
    in_point_y <= y;
    in_param_t <= t;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_points != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] v);
    start <= 1'b0;
    psel <= 1;
    pwrite <= 1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic rand_t_eval();
    int s;
    logic [16:0] t;
    s = $urandom_range(0, 9);
    t = (s == 0) ? 17'h10000 : (s == 1) ? 17'h1FFFF : (s == 2) ? 17'd0 :
        17'($urandom_range(0, 131071));
    if (s > 5) t = 17'($urandom_range(0, 65536));
    issue(KIND_EVAL, '0, '0, t);
  endtask

  task automatic rand_item();
    if ($urandom_range(0, 2) == 0)
      issue(KIND_LOAD, 12'($urandom), 12'($urandom), 17'($urandom));
    else rand_t_eval();
  endtask

  initial begin
    int n, k, total;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // store empty: missing-points status, then order above count
    issue(KIND_EVAL, '0, '0, 17'd100);
    reg_write(ADDR_COUNT, 32'd2);
    reg_write(ADDR_ORDER, 32'd3);
    issue(KIND_EVAL, '0, '0, 17'd100);
    reg_write(ADDR_COUNT, 32'd4);
    issue(KIND_LOAD, 12'd0, 12'hFFF, '0);
    issue(KIND_LOAD, 12'hFFF, 12'd0, '0);
    issue(KIND_LOAD, 12'hAAA, 12'h555, '0);
    issue(KIND_LOAD, 12'h555, 12'hAAA, '0);
    // store full: drop this one
    issue(KIND_LOAD, 12'h123, 12'h321, '0);
    issue(KIND_EVAL, '0, '0, 17'd0);
    issue(KIND_EVAL, '0, '0, 17'h10000);
    issue(KIND_EVAL, '0, '0, 17'h1FFFF);
    issue(KIND_EVAL, '0, '0, 17'h8000);
    issue(KIND_EVAL, '0, '0, 17'hFFFF);
    drain();
    // fewer points than loaded, then out-of-range registers
    reg_write(ADDR_COUNT, 32'd2);
    reg_write(ADDR_ORDER, 32'd2);
    issue(KIND_EVAL, '0, '0, 17'h4000);
    drain();
    reg_write(ADDR_COUNT, 32'd0);
    reg_write(ADDR_ORDER, 32'd0);
    issue(KIND_EVAL, '0, '0, 17'h4000);
    drain();
    reg_write(ADDR_COUNT, 32'd127);
    reg_write(ADDR_ORDER, 32'd15);
    issue(KIND_EVAL, '0, '0, 17'h4000);
    drain();
    // fill the store to its maximum over random phases
    total = 0;
    while (total < 510) begin
      n = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
      k = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(2, 5);
      if ($urandom_range(0, 4) == 0) k = $urandom_range(0, 15);
      reg_write(ADDR_COUNT, n);
      reg_write(ADDR_ORDER, k);
      for (int i = 0; i < 30; i++) begin
        idle_gap();
        rand_item();
        total++;
      end
      drain();
    end
    reg_write(ADDR_COUNT, 32'd64);
    reg_write(ADDR_ORDER, 32'd8);
    for (int i = 0; i < 64; i++) issue(KIND_LOAD, 12'($urandom), 12'($urandom), '0);
    for (int i = 0; i < 6; i++) rand_t_eval();
    drain();
    if (fail_count == 0) $display("bspline_curve_evaluator test passed");
    else $display("bspline_curve_evaluator test failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("bspline_curve_evaluator test failed");
    $finish;
  end
endmodule
